@@ hw/rtl/three_field_frame_parser_top_assert.svh @@
// Assertion macros for the three-field frame parser.
// Used by the top level; depends on nothing else.
`ifndef THREE_FIELD_FRAME_PARSER_TOP_ASSERT_SVH
`define THREE_FIELD_FRAME_PARSER_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define TFFP_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tffp assertion failed");

// Next-cycle implication, checked outside reset.
`define TFFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tffp assertion failed");

`endif

@@ hw/rtl/tffp_pkg.sv @@
// Shared types and constants of the three-field frame parser.
// No dependencies; imported by every other file of the block but the assertion header.
`timescale 1ns / 1ps

package tffp_pkg;

    // Field limits and widths.
    localparam int MAX_FIELD_BYTES = 4;
    localparam int STORE_BYTES     = 4;
    localparam int BYTE_W          = 8;
    localparam int TEXT_W          = STORE_BYTES * BYTE_W;
    localparam int LEN_W           = 3;
    localparam int FCNT_W          = $clog2(MAX_FIELD_BYTES + 1);
    localparam int CFG_IDX_W       = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_START      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SEPARATOR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TERMINATOR = 2'd2;

    // Reset values of the delimiter registers.
    localparam logic [BYTE_W-1:0] START_RESET      = 8'd84;
    localparam logic [BYTE_W-1:0] SEPARATOR_RESET  = 8'd59;
    localparam logic [BYTE_W-1:0] TERMINATOR_RESET = 8'd10;

    // Parser phase, one-hot.
    typedef enum logic [3:0] {
        PH_IDLE  = 4'b0001,
        PH_FIRST = 4'b0010,
        PH_SECND = 4'b0100,
        PH_THIRD = 4'b1000
    } t_phase;

    // Contents of the input register handed to the parse stage.
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] rx_byte;
    } t_in_stage;

    // One result item.
    typedef struct packed {
        logic              frame_done;
        logic              frame_error;
        logic              in_frame;
        logic [TEXT_W-1:0] battery_text;
        logic [LEN_W-1:0]  battery_len;
        logic [TEXT_W-1:0] left_text;
        logic [LEN_W-1:0]  left_len;
        logic [TEXT_W-1:0] right_text;
        logic [LEN_W-1:0]  right_len;
    } t_result;

endpackage

@@ hw/rtl/tffp_ifs.sv @@
// Valid/ready channel interfaces for received bytes and parse results.
// Depends on tffp_pkg.
`timescale 1ns / 1ps

interface tffp_in_if import tffp_pkg::*;;
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface tffp_out_if import tffp_pkg::*;;
    logic              valid;
    logic              ready;
    logic              frame_done;
    logic              frame_error;
    logic              in_frame;
    logic [TEXT_W-1:0] battery_text;
    logic [LEN_W-1:0]  battery_len;
    logic [TEXT_W-1:0] left_text;
    logic [LEN_W-1:0]  left_len;
    logic [TEXT_W-1:0] right_text;
    logic [LEN_W-1:0]  right_len;

    modport source (output valid, output frame_done, output frame_error, output in_frame,
                    output battery_text, output battery_len, output left_text,
                    output left_len, output right_text, output right_len, input ready);
    modport sink   (input valid, input frame_done, input frame_error, input in_frame,
                    input battery_text, input battery_len, input left_text,
                    input left_len, input right_text, input right_len, output ready);
endinterface

@@ hw/rtl/tffp_in_stage.sv @@
// Input register of the frame parser: holds one received byte until the
// parse stage consumes it. Depends on tffp_pkg and tffp_ifs.
`timescale 1ns / 1ps

module tffp_in_stage import tffp_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    tffp_in_if.sink    i_in,
    input  logic       i_advance,
    output t_in_stage  o_stage
);

    logic              r_valid;
    logic              n_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              w_take;

    // A new byte may enter when the register is empty or is consumed now.
    assign i_in.ready = !r_valid || i_advance;
    assign w_take     = i_in.valid && i_in.ready;

    always_comb begin
        n_valid = r_valid;
        if (w_take) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_byte <= i_in.rx_byte;
        end
    end

    assign o_stage.valid   = r_valid;
    assign o_stage.rx_byte = r_byte;

endmodule

@@ hw/rtl/tffp_parse_core.sv @@
// Parse stage: delimiter registers, frame state, per-byte update and the
// result register. Depends on tffp_pkg and tffp_ifs.
`timescale 1ns / 1ps

module tffp_parse_core import tffp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_wdata,
    input  t_in_stage            i_stage,
    output logic                 o_advance,
    tffp_out_if.source           o_out
);

    // Delimiter registers.
    logic [BYTE_W-1:0] r_start;
    logic [BYTE_W-1:0] r_sep;
    logic [BYTE_W-1:0] r_term;

    // Frame state.
    t_phase            r_phase,  n_phase;
    logic [FCNT_W-1:0] r_fcnt,   n_fcnt;
    logic [TEXT_W-1:0] r_bstore, n_bstore;
    logic [FCNT_W-1:0] r_bcnt,   n_bcnt;
    logic [TEXT_W-1:0] r_lstore, n_lstore;
    logic [FCNT_W-1:0] r_lcnt,   n_lcnt;
    logic [TEXT_W-1:0] r_rstore, n_rstore;

    // Result register.
    logic              r_out_valid;
    t_result           r_res;
    t_result           n_res;

    logic [BYTE_W-1:0] w_byte;
    logic [BYTE_W-1:0] w_delim;
    logic [TEXT_W-1:0] w_put;

    // Writes a byte into the store lane picked by the field position.
    // Positions past the store width leave the store unchanged.
    function automatic logic [TEXT_W-1:0] put_byte(
        input logic [TEXT_W-1:0] store,
        input logic [FCNT_W-1:0] pos,
        input logic [BYTE_W-1:0] b
    );
        logic [TEXT_W-1:0] res;
        res = store;
        for (int k = 0; k < STORE_BYTES; k++) begin
            if (32'(pos) == 32'(k)) begin
                res[k*BYTE_W +: BYTE_W] = b;
            end
        end
        return res;
    endfunction

    // The stage advances when a byte is waiting and the result slot frees up.
    assign o_advance = i_stage.valid && (!r_out_valid || o_out.ready);
    assign w_byte    = i_stage.rx_byte;

    // Configuration writes; unknown indexes are dropped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= START_RESET;
            r_sep   <= SEPARATOR_RESET;
            r_term  <= TERMINATOR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_START:      r_start <= i_cfg_wdata;
                CFG_SEPARATOR:  r_sep   <= i_cfg_wdata;
                CFG_TERMINATOR: r_term  <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // The third field ends on the terminator, the others on the separator.
    assign w_delim = (r_phase == PH_THIRD) ? r_term : r_sep;

    // Store lane update for the field now being built.
    always_comb begin
        unique case (r_phase)
            PH_FIRST: w_put = put_byte(r_bstore, r_fcnt, w_byte);
            PH_SECND: w_put = put_byte(r_lstore, r_fcnt, w_byte);
            PH_THIRD: w_put = put_byte(r_rstore, r_fcnt, w_byte);
            default:  w_put = r_rstore;
        endcase
    end

    // Per-byte state update and result.
    always_comb begin
        n_phase  = r_phase;
        n_fcnt   = r_fcnt;
        n_bstore = r_bstore;
        n_bcnt   = r_bcnt;
        n_lstore = r_lstore;
        n_lcnt   = r_lcnt;
        n_rstore = r_rstore;
        n_res    = '0;

        unique case (r_phase) inside
            PH_IDLE: begin
                if (w_byte == r_start) begin
                    n_phase  = PH_FIRST;
                    n_fcnt   = '0;
                    n_bstore = '0;
                    n_bcnt   = '0;
                    n_lstore = '0;
                    n_lcnt   = '0;
                    n_rstore = '0;
                end
            end
            PH_FIRST, PH_SECND, PH_THIRD: begin
                if (w_byte == w_delim) begin
                    n_fcnt = '0;
                    if (r_phase == PH_FIRST) begin
                        n_bcnt  = r_fcnt;
                        n_phase = PH_SECND;
                    end else if (r_phase == PH_SECND) begin
                        n_lcnt  = r_fcnt;
                        n_phase = PH_THIRD;
                    end else begin
                        n_phase            = PH_IDLE;
                        n_res.frame_done   = 1'b1;
                        n_res.battery_text = r_bstore;
                        n_res.battery_len  = LEN_W'(r_bcnt);
                        n_res.left_text    = r_lstore;
                        n_res.left_len     = LEN_W'(r_lcnt);
                        n_res.right_text   = r_rstore;
                        n_res.right_len    = LEN_W'(r_fcnt);
                    end
                end else if (32'(r_fcnt) >= MAX_FIELD_BYTES) begin
                    // Field overflow: drop the byte and abort the frame.
                    n_res.frame_error = 1'b1;
                    n_phase           = PH_IDLE;
                    n_fcnt            = '0;
                end else begin
                    if (r_phase == PH_FIRST) begin
                        n_bstore = w_put;
                    end else if (r_phase == PH_SECND) begin
                        n_lstore = w_put;
                    end else begin
                        n_rstore = w_put;
                    end
                    n_fcnt = r_fcnt + FCNT_W'(1);
                end
            end
            default: begin
                n_phase = PH_IDLE;
            end
        endcase

        n_res.in_frame = (n_phase != PH_IDLE);
    end

    // Frame state advances only on a consumed byte.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_fcnt   <= '0;
            r_bstore <= '0;
            r_bcnt   <= '0;
            r_lstore <= '0;
            r_lcnt   <= '0;
            r_rstore <= '0;
        end else if (o_advance) begin
            r_phase  <= n_phase;
            r_fcnt   <= n_fcnt;
            r_bstore <= n_bstore;
            r_bcnt   <= n_bcnt;
            r_lstore <= n_lstore;
            r_lcnt   <= n_lcnt;
            r_rstore <= n_rstore;
        end
    end

    // Result valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_res <= n_res;
        end
    end

    assign o_out.valid        = r_out_valid;
    assign o_out.frame_done   = r_res.frame_done;
    assign o_out.frame_error  = r_res.frame_error;
    assign o_out.in_frame     = r_res.in_frame;
    assign o_out.battery_text = r_res.battery_text;
    assign o_out.battery_len  = r_res.battery_len;
    assign o_out.left_text    = r_res.left_text;
    assign o_out.left_len     = r_res.left_len;
    assign o_out.right_text   = r_res.right_text;
    assign o_out.right_len    = r_res.right_len;

endmodule

@@ hw/rtl/three_field_frame_parser_top.sv @@
// Channel     Direction  Handshake        Payload
// i_in        in         valid / ready    rx_byte
// o_out       out        valid / ready    done, error, in_frame, three texts and lengths
// i_cfg_*     in         write enable     register index, write data
//
// One byte per cycle sustained while the output is not stalled; a result passes
// through the input register, then the result register. The rate is set by the
// frame state update between those registers. Synchronous active-low reset
// restores the default delimiters and the idle state. A stalled output holds its
// result and lets one more byte wait in the input register.
`timescale 1ns / 1ps
`include "three_field_frame_parser_top_assert.svh"

module three_field_frame_parser_top import tffp_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [BYTE_W-1:0]    i_cfg_wdata,
    tffp_in_if.sink              i_in,
    tffp_out_if.source           o_out
);

    t_in_stage w_stage;
    logic      w_advance;

    // Input register.
    tffp_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_in      (i_in),
        .i_advance (w_advance),
        .o_stage   (w_stage)
    );

    // Frame parsing and result register.
    tffp_parse_core u_parse_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_stage     (w_stage),
        .o_advance   (w_advance),
        .o_out       (o_out)
    );

    // A result never reports both a finished and an aborted frame.
    `TFFP_ASSERT_NOW(a_done_err_excl, i_clk, i_rst_n, o_out.valid,
        !(o_out.frame_done && o_out.frame_error))

    // An aborted or finished frame leaves the parser idle.
    `TFFP_ASSERT_NOW(a_closed_not_open, i_clk, i_rst_n,
        o_out.valid && (o_out.frame_done || o_out.frame_error), !o_out.in_frame)

    // Field data is shown only with a finished frame.
    `TFFP_ASSERT_NOW(a_fields_zero, i_clk, i_rst_n, o_out.valid && !o_out.frame_done,
        (o_out.battery_len == '0) && (o_out.left_len == '0) && (o_out.right_len == '0) &&
        (o_out.battery_text == '0) && (o_out.left_text == '0) && (o_out.right_text == '0))

    // Input back-pressure only while a byte is held in the input register.
    `TFFP_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !i_in.ready, w_stage.valid)

    // A consumed byte always yields a result next cycle.
    `TFFP_ASSERT_NEXT(a_advance_result, i_clk, i_rst_n, w_advance, o_out.valid)

endmodule
